// ===== hdl/sfra_pkg.sv =====
// ----------------------------------------------------------------------------
// sfra_pkg: shared types and constants for the serial frame receiver
// Operation and result codes, frame layout constants and parameter defaults.
// ----------------------------------------------------------------------------
package sfra_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OpByte  = 2'd0,
    OpStart = 2'd1,
    OpTick  = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindFrameEnd = 2'd1,
    KindTimeout  = 2'd2
  } kind_e;

  // Frame layout: dest, len, src, hdr, payload, checksum
  localparam int unsigned FrameOverhead = 5;
  localparam int unsigned FrameMax      = 260;
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned PosW          = 9;

  localparam int unsigned TimeoutBitsDefault = 16;
  localparam logic [7:0]  OwnAddrReset       = 8'h01;

endpackage

// ===== hdl/serial_frame_receiver_addr_filter.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_addr_filter: byte-serial bus frame receiver
// Parses dest/len/src/hdr/payload/checksum frames, filters replies by address,
// streams payload bytes, reports the checksum verdict and a tick timeout.
// ----------------------------------------------------------------------------
// Registers: each item's result is loaded from the input reg into the result reg.
// Throughput: one item per cycle while results are taken at the output; the
//   input register drains into the result register, and items that give no
//   result drain even while a result is stalled at the output.
// Reset: async active low; idle (not listening), all counters zero, own
//   address 1. Payload registers are not reset.
module serial_frame_receiver_addr_filter #(
  parameter int unsigned TIMEOUT_BITS = sfra_pkg::TimeoutBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  peer_address_i,
  input  logic        filter_enable_i,
  input  logic [15:0] timeout_ms_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  frame_destination_o,
  output logic [7:0]  frame_source_o,
  output logic [7:0]  header_code_o,
  output logic [7:0]  payload_length_o,
  output logic        checksum_ok_o
);
  import sfra_pkg::*;

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic [7:0] own_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OwnAddrReset;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic        st_valid_q;
  logic [1:0]  st_op_q;
  logic [7:0]  st_byte_q;
  logic [7:0]  st_peer_q;
  logic        st_filt_q;
  logic [15:0] st_tmo_q;
  logic        in_accept;
  logic        advance;

  assign in_ready_o = !st_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (in_accept) begin
      st_valid_q <= 1'b1;
    end else if (advance) begin
      st_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      st_op_q   <= operation_i;
      st_byte_q <= rx_byte_i;
      st_peer_q <= peer_address_i;
      st_filt_q <= filter_enable_i;
      st_tmo_q  <= timeout_ms_i;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver state
  // --------------------------------------------------------------------------
  logic                    listen_q,  listen_d;
  logic [PosW-1:0]         pos_q,     pos_d;
  logic [7:0]              sum_q,     sum_d;
  logic [7:0]              dest_q,    dest_d;
  logic [7:0]              len_q,     len_d;
  logic [7:0]              src_q,     src_d;
  logic [7:0]              hdr_q,     hdr_d;
  logic [7:0]              peer_q,    peer_d;
  logic                    filt_q,    filt_d;
  logic [TIMEOUT_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIMEOUT_BITS-1:0] limit_q,   limit_d;

  // result of the item in the input register
  logic       has_res;
  kind_e      res_kind;
  logic [7:0] res_byte;
  logic [7:0] res_idx;
  logic [7:0] res_dest;
  logic [7:0] res_src;
  logic [7:0] res_hdr;
  logic [7:0] res_len;
  logic       res_ok;

  // helpers
  logic                    frame_pass;
  logic [7:0]              sum_add;
  logic [TIMEOUT_BITS-1:0] elapsed_inc;
  logic [TIMEOUT_BITS-1:0] new_limit;
  logic                    in_payload;
  logic [PosW-1:0]         payload_off;

  // Reply filter: drop our own echo, else require peer -> own.
  assign frame_pass = !filt_q ||
                      (!(src_q == own_addr_q && dest_q == peer_q) &&
                       src_q == peer_q && dest_q == own_addr_q);

  assign sum_add     = sum_q + st_byte_q;
  assign elapsed_inc = elapsed_q + TIMEOUT_BITS'(1);
  assign new_limit   = TIMEOUT_BITS'(st_tmo_q);
  // bytes before the checksum: position + 1 < len + overhead
  assign in_payload  = ((PosW'(len_q) + PosW'(FrameOverhead)) > (pos_q + PosW'(1))) &&
                       (pos_q < PosW'(FrameMax));
  assign payload_off = pos_q - PosW'(HeaderBytes);

  always_comb begin
    listen_d  = listen_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    dest_d    = dest_q;
    len_d     = len_q;
    src_d     = src_q;
    hdr_d     = hdr_q;
    peer_d    = peer_q;
    filt_d    = filt_q;
    elapsed_d = elapsed_q;
    limit_d   = limit_q;

    has_res  = 1'b0;
    res_kind = KindTimeout;
    res_byte = '0;
    res_idx  = '0;
    res_dest = '0;
    res_src  = '0;
    res_hdr  = '0;
    res_len  = '0;
    res_ok   = 1'b0;

    case (st_op_q)
      OpStart: begin
        // arm (or re-arm), dropping any partial frame; a zero timeout reports a timeout instead
        peer_d    = st_peer_q;
        filt_d    = st_filt_q;
        limit_d   = new_limit;
        elapsed_d = '0;
        pos_d     = '0;
        sum_d     = '0;
        if (new_limit == '0) begin
          listen_d = 1'b0;
          has_res  = 1'b1;
          res_kind = KindTimeout;
        end else begin
          listen_d = 1'b1;
        end
      end
      OpTick: begin
        if (listen_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= limit_q) begin
            listen_d = 1'b0;
            pos_d    = '0;
            sum_d    = '0;
            has_res  = 1'b1;
            res_kind = KindTimeout;
          end
        end
      end
      OpByte: begin
        if (listen_q) begin
          if (pos_q == PosW'(0)) begin
            dest_d = st_byte_q;
            sum_d  = st_byte_q;
            pos_d  = PosW'(1);
          end else begin
            sum_d = sum_add;
            if (pos_q == PosW'(1)) begin
              len_d = st_byte_q;
              pos_d = PosW'(2);
            end else if (pos_q == PosW'(2)) begin
              src_d = st_byte_q;
              pos_d = PosW'(3);
            end else if (pos_q == PosW'(3)) begin
              hdr_d = st_byte_q;
              pos_d = PosW'(HeaderBytes);
            end else if (in_payload) begin
              pos_d = pos_q + PosW'(1);
              if (frame_pass) begin
                has_res  = 1'b1;
                res_kind = KindPayload;
                res_byte = st_byte_q;
                res_idx  = payload_off[7:0];
                res_dest = dest_q;
                res_src  = src_q;
                res_hdr  = hdr_q;
                res_len  = len_q;
              end
            end else begin
              // checksum byte closes the frame
              pos_d = '0;
              sum_d = '0;
              if (frame_pass) begin
                if (sum_add == 8'd0) begin
                  listen_d = 1'b0;
                end
                has_res  = 1'b1;
                res_kind = KindFrameEnd;
                res_dest = dest_q;
                res_src  = src_q;
                res_hdr  = hdr_q;
                res_len  = len_q;
                res_ok   = (sum_add == 8'd0);
              end
            end
          end
        end
      end
      default: begin
        // unused operation code: no effect
      end
    endcase
  end

  // An item leaves the input register unless its result has no room.
  assign advance = st_valid_q && (!has_res || !out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_q  <= 1'b0;
      pos_q     <= '0;
      sum_q     <= '0;
      dest_q    <= '0;
      len_q     <= '0;
      src_q     <= '0;
      hdr_q     <= '0;
      peer_q    <= '0;
      filt_q    <= 1'b0;
      elapsed_q <= '0;
      limit_q   <= '0;
    end else if (advance) begin
      listen_q  <= listen_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      dest_q    <= dest_d;
      len_q     <= len_d;
      src_q     <= src_d;
      hdr_q     <= hdr_d;
      peer_q    <= peer_d;
      filt_q    <= filt_d;
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic out_load;

  assign out_load    = advance && has_res;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_kind_o       <= res_kind;
      payload_byte_o      <= res_byte;
      payload_index_o     <= res_idx;
      frame_destination_o <= res_dest;
      frame_source_o      <= res_src;
      header_code_o       <= res_hdr;
      payload_length_o    <= res_len;
      checksum_ok_o       <= res_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_kind == KindTimeout) |=> !listen_q)
    else $error("listening after timeout result");

  a_good_frame_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_kind == KindFrameEnd && res_ok) |=> !listen_q)
    else $error("listening after good frame");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(FrameMax))
    else $error("byte position past frame maximum");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid_q && !advance) |=> (st_valid_q && $stable(st_op_q)))
    else $error("stalled item lost from input register");

endmodule
